/* design/fkpi_pkg.sv */
package fkpi_pkg;

   localparam int KMER_LEN    = 9;
   localparam int WIN_LEN     = 4 * KMER_LEN + 1;
   localparam int CENTER_LEN  = 2 * KMER_LEN + 1;
   localparam int KMER_W      = 2 * KMER_LEN;
   localparam int PROD_W      = 2 * KMER_W;
   localparam int INDEX_W     = 35;
   localparam int SUM_W       = (PROD_W > INDEX_W + 1) ? PROD_W : INDEX_W + 1;
   localparam int SEEN_W      = $clog2(WIN_LEN);
   localparam int FULL_COUNT  = 4 * KMER_LEN;
   localparam int PAIRS       = 2;
   localparam int PAIR_OUTER  = 0;
   localparam int PAIR_INNER  = 1;
   // power of two: pointers wrap on their own
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [KMER_W-1:0] kmer_type;

   typedef struct packed {
      logic [1:0] code;
      logic       is_n;
   } base_type;

   typedef struct packed {
      logic       first_of_read;
      logic [1:0] noise_base;
      logic       noise_is_n;
      logic [1:0] center_base;
      logic       center_is_n;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] pattern_index;
      logic               center_class;
      logic               inner_pair;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      kmer_type left;
      kmer_type right;
      logic     has_n;
   } pair_src_type;

   typedef struct packed {
      logic                          valid;
      logic                          cls;
      pair_src_type [PAIRS-1:0]      pair;
   } window_out_type;

   typedef struct packed {
      logic                            cls;
      logic [PAIRS-1:0]                emit;
      logic [PAIRS-1:0][INDEX_W-1:0]   index;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

endpackage

/* design/fkpi_req_if.sv */
interface fkpi_req_if import fkpi_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type beat;

   modport source (output valid, output beat, input ready);
   modport sink (input valid, input beat, output ready);
endinterface

/* design/fkpi_rsp_if.sv */
interface fkpi_rsp_if import fkpi_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type beat;

   modport source (output valid, output beat, input ready);
   modport sink (input valid, input beat, output ready);
endinterface

/* design/flanking_kmer_pair_indexer.sv */
// Path: an accepted beat passes the window register, then the product register, then the queue.
// Throughput: one beat per cycle unless backpressured, one record per cycle while the sink is
// ready; the two-stage pair pipeline (window register, product register) feeds a four-entry
// queue, so a beat that yields two records holds the result port until both are taken.
// Reset: synchronous, active high; clears the base count, stage valids and the queue.
// The window is not cleared, since a read refills every slot before it is used.
module flanking_kmer_pair_indexer import fkpi_pkg::*; (
   input logic         clock,
   input logic         reset,
   fkpi_req_if.sink    req_bus,
   fkpi_rsp_if.source  rsp_bus
);

   logic           accept;
   logic           space_ok;
   logic           pair_busy;
   window_out_type window;
   push_type       push;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = space_ok;

   fkpi_window u_window (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .beat   (req_bus.beat),
      .window (window)
   );

   fkpi_pair u_pair (
      .clock  (clock),
      .reset  (reset),
      .window (window),
      .push   (push),
      .busy   (pair_busy)
   );

   fkpi_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .window_busy (window.valid),
      .pair_busy   (pair_busy),
      .space_ok    (space_ok),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .rsp_beat    (rsp_bus.beat)
   );

endmodule

/* design/fkpi_window.sv */
module fkpi_window import fkpi_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  req_type        beat,
   output window_out_type window
);

   base_type          flank_ff [WIN_LEN];
   base_type          center_ff [CENTER_LEN];
   logic [SEEN_W-1:0] seen_ff;
   logic [SEEN_W-1:0] seen_in;
   logic [SEEN_W-1:0] seen_base;
   logic              valid_ff;
   logic              valid_in;
   logic              fire;

   always_comb begin
      seen_base = beat.first_of_read ? '0 : seen_ff;
      fire      = seen_base >= SEEN_W'(FULL_COUNT);
      seen_in   = seen_ff;
      if (accept) begin
         seen_in = fire ? seen_base : seen_base + 1'b1;
      end
      // center lands at the oldest slot after this shift
      valid_in = accept && fire && !center_ff[CENTER_LEN-2].is_n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         seen_ff  <= seen_in;
         valid_ff <= valid_in;
      end
   end

   // no clear needed: a full read rewrites every slot before any use
   always_ff @(posedge clock) begin
      if (accept) begin
         flank_ff[0]  <= '{code: beat.noise_base, is_n: beat.noise_is_n};
         center_ff[0] <= '{code: beat.center_base, is_n: beat.center_is_n};
         for (int i = 1; i < WIN_LEN; i++) begin
            flank_ff[i] <= flank_ff[i-1];
         end
         for (int i = 1; i < CENTER_LEN; i++) begin
            center_ff[i] <= center_ff[i-1];
         end
      end
   end

   always_comb begin
      window       = '0;
      window.valid = valid_ff;
      window.cls   = center_ff[CENTER_LEN-1].code[0];
      for (int i = 0; i < KMER_LEN; i++) begin
         window.pair[PAIR_OUTER].left[2*i +: 2]  = flank_ff[3*KMER_LEN+1+i].code;
         window.pair[PAIR_OUTER].right[2*i +: 2] = ~flank_ff[KMER_LEN-1-i].code;
         window.pair[PAIR_INNER].left[2*i +: 2]  = flank_ff[2*KMER_LEN+1+i].code;
         window.pair[PAIR_INNER].right[2*i +: 2] = ~flank_ff[2*KMER_LEN-1-i].code;
         window.pair[PAIR_OUTER].has_n = window.pair[PAIR_OUTER].has_n
                                        | flank_ff[3*KMER_LEN+1+i].is_n
                                        | flank_ff[KMER_LEN-1-i].is_n;
         window.pair[PAIR_INNER].has_n = window.pair[PAIR_INNER].has_n
                                        | flank_ff[2*KMER_LEN+1+i].is_n
                                        | flank_ff[2*KMER_LEN-1-i].is_n;
      end
   end

endmodule

/* design/fkpi_pair.sv */
module fkpi_pair import fkpi_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  window_out_type window,
   output push_type       push,
   output logic           busy
);

   logic                valid_ff;
   logic                cls_ff;
   logic [PAIRS-1:0]    emit_ff;
   logic [PAIRS-1:0]    emit_in;
   logic [SUM_W-1:0]    prod_ff [PAIRS];
   logic [SUM_W-1:0]    prod_in [PAIRS];
   kmer_type            right_ff [PAIRS];
   kmer_type            left_m1 [PAIRS];
   logic [PROD_W-1:0]   mult [PAIRS];

   always_comb begin
      for (int p = 0; p < PAIRS; p++) begin
         left_m1[p] = window.pair[p].left - KMER_W'(1);
         mult[p]    = window.pair[p].left * left_m1[p];
         prod_in[p] = SUM_W'(mult[p]);
         emit_in[p] = !window.pair[p].has_n
                      && (window.pair[p].left > window.pair[p].right);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= window.valid;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff  <= window.cls;
      emit_ff <= emit_in;
      for (int p = 0; p < PAIRS; p++) begin
         prod_ff[p]  <= prod_in[p];
         right_ff[p] <= window.pair[p].right;
      end
   end

   always_comb begin
      push.valid      = valid_ff && (|emit_ff);
      push.entry.cls  = cls_ff;
      push.entry.emit = emit_ff;
      for (int p = 0; p < PAIRS; p++) begin
         push.entry.index[p] = prod_ff[p][INDEX_W:1] + INDEX_W'(right_ff[p]);
      end
   end

   assign busy = valid_ff;

endmodule

/* design/fkpi_queue.sv */
module fkpi_queue import fkpi_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     window_busy,
   input  logic     pair_busy,
   output logic     space_ok,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_beat
);

   entry_type         mem_ff [QUEUE_DEPTH];
   entry_type         head;
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic [QCNT_W:0]   occupancy;
   logic              outer_done_ff;
   logic              show_outer;
   logic              pop;
   logic              pop_last;

   always_comb begin
      occupancy = (QCNT_W+1)'(count_ff) + (QCNT_W+1)'(window_busy)
                  + (QCNT_W+1)'(pair_busy);
      space_ok  = occupancy < (QCNT_W+1)'(QUEUE_DEPTH);

      head       = mem_ff[rd_ptr_ff];
      show_outer = head.emit[PAIR_OUTER] && !outer_done_ff;
      rsp_valid  = count_ff != '0;

      rsp_beat.pattern_index = show_outer ? head.index[PAIR_OUTER] : head.index[PAIR_INNER];
      rsp_beat.center_class  = head.cls;
      rsp_beat.inner_pair    = !show_outer;
      rsp_beat.last_of_run   = !show_outer || !head.emit[PAIR_INNER];

      pop      = rsp_valid && rsp_ready;
      pop_last = pop && rsp_beat.last_of_run;

      count_in = count_ff;
      if (push.valid && !pop_last) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && pop_last) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         outer_done_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_last) begin
            rd_ptr_ff     <= rd_ptr_ff + 1'b1;
            outer_done_ff <= 1'b0;
         end else if (pop) begin
            outer_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

/* tb/tb_flanking_kmer_pair_indexer.sv */
`timescale 1ns / 100ps

module tb_flanking_kmer_pair_indexer;
   import fkpi_pkg::*;

   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   localparam int RANDOM_BEATS = 160;
   localparam int QUIET_START  = 40;
   localparam int QUIET_BEATS  = 60;
   localparam int HOLD_CYCLES  = 200;
   localparam int STALL_LIMIT  = 2000;
   localparam int MAX_REPORTS  = 40;

   logic clock;
   logic reset;

   fkpi_req_if req_bus ();
   fkpi_rsp_if rsp_bus ();

   flanking_kmer_pair_indexer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // predicted window, index 0 is newest
   logic [1:0] win_code [WIN_LEN];
   logic       win_n    [WIN_LEN];
   logic [1:0] ctr_code [CENTER_LEN];
   logic       ctr_n    [CENTER_LEN];
   int         bases_seen;

   rsp_type expected_records [$];
   rsp_type missing;

   int  errors;
   int  beats_sent;
   int  reads_started;
   int  records_checked;
   int  quiet_cycles;
   int  hold_left;
   bit  calm;

   always #10 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (errors < MAX_REPORTS)
         $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
      errors++;
   endtask

   function automatic void queue_record(input rsp_type rec);
      expected_records = {expected_records, rec};
   endfunction

   function automatic void clear_window();
      for (int i = 0; i < WIN_LEN; i++) begin
         win_code[i] = BASE_A;
         win_n[i]    = 1'b0;
      end
      for (int i = 0; i < CENTER_LEN; i++) begin
         ctr_code[i] = BASE_A;
         ctr_n[i]    = 1'b0;
      end
      bases_seen = 0;
   endfunction

   function automatic kmer_type forward_kmer(int hi);
      kmer_type v;
      v = '0;
      for (int d = hi; d > hi - KMER_LEN; d--)
         v = {v[KMER_W-3:0], win_code[d]};
      return v;
   endfunction

   function automatic kmer_type revcomp_kmer(int lo);
      kmer_type v;
      v = '0;
      for (int d = lo; d < lo + KMER_LEN; d++)
         v = {v[KMER_W-3:0], BASE_T ^ win_code[d]};
      return v;
   endfunction

   function automatic bit span_has_n(int lo);
      bit n;
      n = 1'b0;
      for (int d = lo; d < lo + KMER_LEN; d++)
         n |= win_n[d];
      return n;
   endfunction

   function automatic bit pair_record(input kmer_type l, input kmer_type r, input bit n,
                                      input logic cls, input int which,
                                      output rsp_type rec);
      logic [63:0] lw;
      logic [63:0] full;
      rec = '0;
      if (n || l <= r)
         return 1'b0;
      lw   = 64'(l);
      full = (lw * (lw - 64'd1)) / 64'd2 + 64'(r);
      rec.pattern_index = full[INDEX_W-1:0];
      rec.center_class  = cls;
      rec.inner_pair    = (which == PAIR_INNER);
      rec.last_of_run   = 1'b0;
      return 1'b1;
   endfunction

   function automatic void predict_records(input req_type b);
      rsp_type found [PAIRS];
      rsp_type rec;
      int      count;
      bit      full;
      logic    cls;
      count = 0;
      if (b.first_of_read)
         clear_window();
      for (int i = WIN_LEN - 1; i > 0; i--) begin
         win_code[i] = win_code[i-1];
         win_n[i]    = win_n[i-1];
      end
      for (int i = CENTER_LEN - 1; i > 0; i--) begin
         ctr_code[i] = ctr_code[i-1];
         ctr_n[i]    = ctr_n[i-1];
      end
      win_code[0] = b.noise_base;
      win_n[0]    = b.noise_is_n;
      ctr_code[0] = b.center_base;
      ctr_n[0]    = b.center_is_n;
      full = (bases_seen >= FULL_COUNT);
      if (!full)
         bases_seen++;
      if (full && !ctr_n[2*KMER_LEN]) begin
         cls = ctr_code[2*KMER_LEN][0];
         if (pair_record(forward_kmer(4*KMER_LEN), revcomp_kmer(0),
                         span_has_n(3*KMER_LEN+1) || span_has_n(0), cls, PAIR_OUTER, rec)) begin
            found[count] = rec;
            count++;
         end
         if (pair_record(forward_kmer(3*KMER_LEN), revcomp_kmer(KMER_LEN),
                         span_has_n(2*KMER_LEN+1) || span_has_n(KMER_LEN), cls, PAIR_INNER,
                         rec)) begin
            found[count] = rec;
            count++;
         end
         if (count > 0)
            found[count-1].last_of_run = 1'b1;
         for (int i = 0; i < count; i++)
            queue_record(found[i]);
      end
   endfunction

   function automatic req_type random_beat(int n_pct);
      req_type b;
      b.first_of_read = 1'b0;
      b.noise_base    = 2'($urandom);
      b.noise_is_n    = ($urandom_range(99) < n_pct);
      b.center_base   = 2'($urandom);
      b.center_is_n   = ($urandom_range(99) < n_pct);
      return b;
   endfunction

   task automatic send_beat(input req_type b);
      while (!calm && $urandom_range(99) < 9) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.beat  <= b;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predict_records(b);
      beats_sent++;
      if (b.first_of_read)
         reads_started++;
   endtask

   task automatic send_random_bases(input int count, input int n_pct, input bit start_read);
      req_type b;
      for (int i = 0; i < count; i++) begin
         b = random_beat(n_pct);
         if (i == 0 && start_read)
            b.first_of_read = 1'b1;
         send_beat(b);
      end
   endtask

   // one full read: L1 L2 center R2 R1, the flanks given as the k-mer values the block sees
   task automatic send_window(input kmer_type l1, input kmer_type l2, input kmer_type r2,
                              input kmer_type r1, input logic [1:0] center,
                              input bit center_n, input bit [3:0] n_block);
      req_type  b;
      int       n_at [4];
      int       blk;
      int       j;
      kmer_type part;
      for (int i = 0; i < 4; i++)
         n_at[i] = $urandom_range(KMER_LEN - 1);
      for (int pos = 0; pos < WIN_LEN; pos++) begin
         b = random_beat(50);
         b.first_of_read = (pos == 0);
         if (pos == 2*KMER_LEN) begin
            b.center_base = center;
            b.center_is_n = center_n;
         end else begin
            blk = (pos < 2*KMER_LEN) ? pos / KMER_LEN : (pos - 1) / KMER_LEN;
            j   = (pos < 2*KMER_LEN) ? pos % KMER_LEN : (pos - 1) % KMER_LEN;
            case (blk)
               0: part = l1;
               1: part = l2;
               2: part = r2;
               default: part = r1;
            endcase
            if (blk < 2)
               b.noise_base = part[KMER_W-1-2*j -: 2];
            else
               b.noise_base = BASE_T ^ part[2*j+1 -: 2];
            b.noise_is_n = n_block[blk] && (j == n_at[blk]);
         end
         send_beat(b);
      end
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (expected_records.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic test_short_reads();
      send_random_bases(FULL_COUNT, 10, 1'b1);
      send_random_bases(1, 10, 1'b1);
      send_random_bases(FULL_COUNT - 1, 0, 1'b1);
      settle();
   endtask

   task automatic test_extreme_pairs();
      kmer_type top;
      kmer_type eq;
      top = '1;
      eq  = kmer_type'($urandom);
      send_window(top, top, top - kmer_type'(1), top - kmer_type'(1), BASE_C, 1'b0, 4'b0000);
      send_window(kmer_type'(1), kmer_type'(1), '0, '0, BASE_A, 1'b0, 4'b0000);
      send_window(eq, '0, top, eq, BASE_G, 1'b0, 4'b0000);
      send_window(top, '0, top, '0, BASE_T, 1'b0, 4'b0000);
      send_window('0, top, '0, top, BASE_A, 1'b0, 4'b0000);
      send_random_bases(6, 0, 1'b0);
      settle();
   endtask

   task automatic test_masked_bases();
      kmer_type top;
      top = '1;
      send_window(top, top, '0, '0, BASE_C, 1'b1, 4'b0000);
      send_window(top, top, '0, '0, BASE_G, 1'b0, 4'b0001);
      send_window(top, top, '0, '0, BASE_T, 1'b0, 4'b0100);
      send_window(top, top, '0, '0, BASE_A, 1'b0, 4'b1010);
      settle();
   endtask

   task automatic test_backpressure();
      calm      = 1'b1;
      hold_left = HOLD_CYCLES;
      send_window('1, '1, '0, '0, BASE_T, 1'b0, 4'b0000);
      send_random_bases(40, 0, 1'b0);
      calm = 1'b0;
      settle();
   endtask

   task automatic test_random_reads();
      int start;
      int kind;
      start = beats_sent;
      while (beats_sent < start + RANDOM_BEATS) begin
         calm = (beats_sent >= start + QUIET_START
                 && beats_sent < start + QUIET_START + QUIET_BEATS);
         kind = $urandom_range(99);
         if (kind < 70) begin
            send_window(kmer_type'($urandom), kmer_type'($urandom), kmer_type'($urandom),
                        kmer_type'($urandom), 2'($urandom), $urandom_range(99) < 8,
                        {$urandom_range(99) < 10, $urandom_range(99) < 10,
                         $urandom_range(99) < 10, $urandom_range(99) < 10});
            send_random_bases($urandom_range(24), 3, 1'b0);
         end else if (kind < 85) begin
            send_random_bases($urandom_range(1, FULL_COUNT), 3, 1'b1);
         end else begin
            send_random_bases($urandom_range(WIN_LEN, 70), 30, 1'($urandom));
         end
      end
      calm = 1'b0;
      settle();
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || ($urandom_range(99) >= 9);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_records.size() == 0) begin
            report_mismatch("record with none expected", 64'(rsp_bus.beat), 64'd0);
         end else begin
            want = expected_records.pop_front();
            records_checked++;
            if (rsp_bus.beat.pattern_index !== want.pattern_index)
               report_mismatch("pattern_index", 64'(rsp_bus.beat.pattern_index),
                               64'(want.pattern_index));
            if (rsp_bus.beat.center_class !== want.center_class)
               report_mismatch("center_class", 64'(rsp_bus.beat.center_class),
                               64'(want.center_class));
            if (rsp_bus.beat.inner_pair !== want.inner_pair)
               report_mismatch("inner_pair", 64'(rsp_bus.beat.inner_pair),
                               64'(want.inner_pair));
            if (rsp_bus.beat.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", 64'(rsp_bus.beat.last_of_run),
                               64'(want.last_of_run));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_flanking_kmer_pair_indexer: errors");
         $finish;
      end
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.beat    = '0;
      rsp_bus.ready   = 1'b0;
      errors          = 0;
      beats_sent      = 0;
      reads_started   = 0;
      records_checked = 0;
      quiet_cycles    = 0;
      hold_left       = 0;
      calm            = 1'b0;
      clear_window();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_reads();
      test_extreme_pairs();
      test_masked_bases();
      test_backpressure();
      test_random_reads();

      while (expected_records.size() != 0) begin
         missing = expected_records.pop_front();
         report_mismatch("record never arrived", 64'd0, 64'(missing.pattern_index));
      end
      $display("run: %0d beats over %0d reads, %0d records checked",
               beats_sent, reads_started, records_checked);
      $display("run: extreme/equal flanks, masked bases, short reads, %0d-cycle hold-off",
               HOLD_CYCLES);
      if (errors == 0)
         $display("tb_flanking_kmer_pair_indexer: clean");
      else
         $display("tb_flanking_kmer_pair_indexer: errors");
      $finish;
   end

endmodule
